// ===== src/csrf_pkg.sv =====
// Shared types and constants for the RV32 CSR file.
// Holds the access codes, CSR addresses, masks and the dedicated register bundle.
// No dependencies.
package csrf_pkg;

  typedef enum logic [1:0] {
    ActRead  = 2'd0,
    ActWrite = 2'd1,
    ActSet   = 2'd2,
    ActClear = 2'd3
  } csrf_action_e;

  localparam logic [11:0] AddrSstatus = 12'h100;
  localparam logic [11:0] AddrSie     = 12'h104;
  localparam logic [11:0] AddrSip     = 12'h144;
  localparam logic [11:0] AddrMstatus = 12'h300;
  localparam logic [11:0] AddrMisa    = 12'h301;
  localparam logic [11:0] AddrMideleg = 12'h303;
  localparam logic [11:0] AddrMie     = 12'h304;
  localparam logic [11:0] AddrMip     = 12'h344;
  localparam logic [11:0] AddrCycle   = 12'hC00;
  localparam logic [11:0] AddrCycleh  = 12'hC80;

  localparam logic [31:0] MstatusWMask = 32'h0004_79AA;
  localparam logic [31:0] SstatusVMask = 32'h0004_6122;
  localparam logic [31:0] MipWMask     = 32'h0000_0222;
  localparam logic [31:0] MisaValue    = 32'h4014_1101;
  localparam logic [31:0] CycleStep    = 32'd10000;
  localparam logic [31:0] MstatusReset = 32'h0000_1800;

  // Machine previous privilege field of mstatus, and the reserved code it must not hold.
  localparam int unsigned MppLsb      = 11;
  localparam logic [1:0]  MppReserved = 2'b10;
  localparam logic [1:0]  ReadOnlyTop = 2'b11;

  typedef struct packed {
    logic [31:0] mstatus;
    logic [31:0] mie;
    logic [31:0] mip;
    logic [31:0] mideleg;
    logic [31:0] cycle;
  } csrf_regs_t;

  typedef struct packed {
    logic        we;
    logic [31:0] wdata;
  } csrf_store_wr_t;

endpackage

// ===== src/csrf_exec.sv =====
// Combinational execution of one CSR transaction.
// Computes the old value, the permission flag and the next state of all registers.
// Depends on csrf_pkg.
module csrf_exec import csrf_pkg::*; (
  input  csrf_action_e   action_i,
  input  logic [11:0]    address_i,
  input  logic [31:0]    value_i,
  input  logic [1:0]     privilege_i,
  input  logic [31:0]    store_rdata_i,
  input  csrf_regs_t     regs_i,
  output csrf_regs_t     regs_o,
  output csrf_store_wr_t store_wr_o,
  output logic [31:0]    read_data_o,
  output logic           access_allowed_o
);

  logic        read_only;
  logic        do_write;
  logic [31:0] cycle_now;
  logic [31:0] old_val;
  logic [31:0] wval;
  logic [31:0] ms_val;
  logic [31:0] sip_mask;

  assign read_only = (address_i[11:10] == ReadOnlyTop);

  // A read of the cycle CSR (plain read, set or clear) advances the counter first.
  assign cycle_now = ((action_i != ActWrite) && (address_i == AddrCycle))
                     ? regs_i.cycle + CycleStep : regs_i.cycle;

  always_comb begin
    case (address_i)
      AddrCycle:   old_val = cycle_now;
      AddrCycleh:  old_val = '0;
      AddrSstatus: old_val = regs_i.mstatus & SstatusVMask;
      AddrSie:     old_val = regs_i.mie & regs_i.mideleg;
      AddrSip:     old_val = regs_i.mip & regs_i.mideleg;
      AddrMstatus: old_val = regs_i.mstatus;
      AddrMisa:    old_val = MisaValue;
      AddrMideleg: old_val = regs_i.mideleg;
      AddrMie:     old_val = regs_i.mie;
      AddrMip:     old_val = regs_i.mip;
      default:     old_val = store_rdata_i;
    endcase
  end

  always_comb begin
    case (action_i)
      ActWrite: wval = value_i;
      ActSet:   wval = old_val | value_i;
      ActClear: wval = old_val & ~value_i;
      default:  wval = old_val;
    endcase
  end

  assign do_write = (action_i != ActRead) && !read_only;

  always_comb begin
    ms_val = wval & MstatusWMask;
    if (ms_val[MppLsb +: 2] == MppReserved) begin
      ms_val[MppLsb +: 2] = 2'b00;
    end
  end

  assign sip_mask = regs_i.mideleg & MipWMask;

  always_comb begin
    regs_o       = regs_i;
    regs_o.cycle = cycle_now;
    store_wr_o   = '{we: 1'b0, wdata: wval};
    if (do_write) begin
      case (address_i)
        AddrMstatus: regs_o.mstatus = ms_val;
        AddrSstatus: regs_o.mstatus = (regs_i.mstatus & ~SstatusVMask)
                                      | (wval & SstatusVMask);
        AddrSie:     regs_o.mie = (regs_i.mie & ~regs_i.mideleg) | (wval & regs_i.mideleg);
        AddrSip:     regs_o.mip = (regs_i.mip & ~sip_mask) | (wval & sip_mask);
        AddrMip:     regs_o.mip = (regs_i.mip & ~MipWMask) | (wval & MipWMask);
        AddrMideleg: regs_o.mideleg = wval;
        AddrMie:     regs_o.mie = wval;
        AddrMisa:    regs_o.mstatus = regs_i.mstatus;
        default:     store_wr_o.we = 1'b1;
      endcase
    end
  end

  assign read_data_o      = old_val;
  assign access_allowed_o = (privilege_i >= address_i[9:8]) &&
                            !((action_i != ActRead) && read_only);

endmodule

// ===== src/riscv_csr_file.sv =====
// Top level of the RV32 CSR file: handshake, pipeline registers and backing store.
// Depends on csrf_pkg and csrf_exec.
// Instantiates csrf_exec for the per-transaction computation.

// The block accepts one CSR transaction per clock cycle while in_stall_o is low. An accepted
// transaction is held in the execute stage register, its result then in an output register,
// so a stalled result holds up new transactions only once the execute stage is full too. A
// transaction is read, write, set bits or clear bits; the result carries the value before
// the access and a permission flag that is only reported, never enforced. The addresses not
// served by dedicated registers live in a single-port-read, single-port-write memory of
// STORE_DEPTH words; its registered read is taken when the transaction is accepted and a
// one-entry bypass covers a write from the transaction just ahead. After reset the block
// zeroes that memory (4096 words by default), one word per cycle, holding in_stall_o high.
module riscv_csr_file import csrf_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  in_action_i,
  input  logic [11:0] in_address_i,
  input  logic [31:0] in_value_i,
  input  logic [1:0]  in_privilege_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_read_data_o,
  output logic        out_access_allowed_o
);

  localparam int unsigned IdxW = $clog2(STORE_DEPTH);

  logic [31:0] store_mem [STORE_DEPTH];

  // Clearing pass state.
  logic            clearing_q;
  logic [IdxW-1:0] clr_idx_q;

  // Execute stage: accepted transaction and its registered memory read.
  logic        s1_valid_q;
  logic [1:0]  s1_action_q;
  logic [11:0] s1_address_q;
  logic [31:0] s1_value_q;
  logic [1:0]  s1_privilege_q;
  logic [31:0] mem_rdata_q;

  // Last word written to the store, forwarded to a following read of the same entry.
  logic            byp_valid_q;
  logic [IdxW-1:0] byp_idx_q;
  logic [31:0]     byp_data_q;

  csrf_regs_t regs_q, regs_d;

  logic        out_valid_q;
  logic [31:0] out_read_data_q;
  logic        out_allowed_q;

  logic           in_accept;
  logic           advance;
  logic [IdxW-1:0] s1_idx;
  logic [31:0]    store_rdata;
  csrf_store_wr_t store_wr;
  logic [31:0]    exec_rdata;
  logic           exec_allowed;
  logic           mem_we;
  logic [IdxW-1:0] mem_widx;
  logic [31:0]    mem_wdata;

  // The execute stage moves on whenever the output register is empty or being drained.
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clearing_q || (s1_valid_q && !advance);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_idx      = s1_address_q[IdxW-1:0];
  assign store_rdata = (byp_valid_q && (byp_idx_q == s1_idx)) ? byp_data_q : mem_rdata_q;

  csrf_exec u_exec (
    .action_i         (csrf_action_e'(s1_action_q)),
    .address_i        (s1_address_q),
    .value_i          (s1_value_q),
    .privilege_i      (s1_privilege_q),
    .store_rdata_i    (store_rdata),
    .regs_i           (regs_q),
    .regs_o           (regs_d),
    .store_wr_o       (store_wr),
    .read_data_o      (exec_rdata),
    .access_allowed_o (exec_allowed)
  );

  // The clearing pass and transaction writes never overlap, since no transaction is taken
  // while clearing.
  assign mem_we    = clearing_q || (advance && store_wr.we);
  assign mem_widx  = clearing_q ? clr_idx_q : s1_idx;
  assign mem_wdata = clearing_q ? '0 : store_wr.wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_widx] <= mem_wdata;
    end
    if (in_accept) begin
      mem_rdata_q <= store_mem[in_address_i[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_idx_q   <= '0;
      s1_valid_q  <= 1'b0;
      byp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      regs_q      <= '{mstatus: MstatusReset, default: '0};
    end else begin
      if (clearing_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (clr_idx_q == IdxW'(STORE_DEPTH - 1)) begin
          clearing_q <= 1'b0;
        end
      end
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        regs_q      <= regs_d;
        out_valid_q <= 1'b1;
        if (store_wr.we) begin
          byp_valid_q <= 1'b1;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_action_q    <= in_action_i;
      s1_address_q   <= in_address_i;
      s1_value_q     <= in_value_i;
      s1_privilege_q <= in_privilege_i;
    end
    if (advance) begin
      out_read_data_q <= exec_rdata;
      out_allowed_q   <= exec_allowed;
      if (store_wr.we) begin
        byp_idx_q  <= s1_idx;
        byp_data_q <= store_wr.wdata;
      end
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_read_data_o      = out_read_data_q;
  assign out_access_allowed_o = out_allowed_q;

`ifndef ASSERT_OFF
  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> in_stall_o)
    else $error("transaction accepted during store clearing");

  a_advance_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("executed transaction left no result");

  a_cycle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (regs_q.cycle != $past(regs_q.cycle)) |-> (regs_q.cycle == $past(regs_q.cycle) + CycleStep))
    else $error("cycle counter moved by other than one step");

  a_mpp_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    regs_q.mstatus[MppLsb +: 2] != MppReserved)
    else $error("mstatus holds the reserved MPP code");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the RV32 CSR file (riscv_csr_file).
// Needs csrf_pkg and the RTL of riscv_csr_file, which instantiates csrf_exec. No other files.
// A directed table runs first, then random accesses; each result is checked against a model or the row's typed value.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csrf_pkg::*;

  // Privilege modes as the block sees them; the reserved mode 2 is compared as a plain number.
  localparam logic [1:0] PrivUser    = 2'd0;
  localparam logic [1:0] PrivSuper   = 2'd1;
  localparam logic [1:0] PrivRsvd    = 2'd2;
  localparam logic [1:0] PrivMachine = 2'd3;

  localparam int StoreDepth    = 4096;
  localparam int RandomCount   = 1100;
  localparam int HoldOffCycles = 150;
  localparam int SettleCycles  = 8;
  // Cycles without any transaction on either side before the run is declared hung; the
  // memory clearing pass after reset is such a quiet stretch.
  localparam int HangLimit     = 20000;

  typedef struct packed {
    logic [31:0] read_data;
    logic        allowed;
  } csr_result_t;

  // One access as offered to the block. When typed is set, the expected result is the one
  // written in the row rather than the one computed by the model below.
  typedef struct packed {
    csrf_action_e action;
    logic [11:0]  address;
    logic [31:0]  value;
    logic [1:0]   privilege;
    logic         typed;
    logic [31:0]  read_data;
    logic         allowed;
  } csr_row_t;

  localparam int DirectedCount = 26;
  localparam csr_row_t DirectedRows [DirectedCount] = '{
    // Values straight after reset, including the privilege check on misa.
    '{ActRead,  AddrMstatus, 32'h0000_0000, PrivMachine, 1'b1, MstatusReset,  1'b1},
    '{ActRead,  AddrMisa,    32'h0000_0000, PrivUser,    1'b1, MisaValue,     1'b0},
    // The cycle counter moves on a read but not on a write; the write is also denied
    // because the address is in the read-only range.
    '{ActRead,  AddrCycle,   32'h0000_0000, PrivUser,    1'b1, CycleStep,     1'b1},
    '{ActWrite, AddrCycle,   32'hFFFF_FFFF, PrivMachine, 1'b1, CycleStep,     1'b0},
    '{ActRead,  AddrCycleh,  32'hFFFF_FFFF, PrivUser,    1'b1, 32'h0,         1'b1},
    // mstatus write mask, then the reserved MPP code collapsing to zero.
    '{ActWrite, AddrMstatus, 32'hFFFF_FFFF, PrivMachine, 1'b1, MstatusReset,  1'b1},
    '{ActRead,  AddrMstatus, 32'h0000_0000, PrivSuper,   1'b1, MstatusWMask,  1'b0},
    '{ActWrite, AddrMstatus, 32'h0000_1000, PrivMachine, 1'b1, MstatusWMask,  1'b1},
    '{ActRead,  AddrMstatus, 32'h0000_0000, PrivMachine, 1'b1, 32'h0,         1'b1},
    '{ActWrite, AddrMstatus, 32'h0000_0800, PrivMachine, 1'b1, 32'h0,         1'b1},
    // Delegate everything, then reach mie and mip through their supervisor views.
    '{ActWrite, AddrMideleg, 32'hFFFF_FFFF, PrivMachine, 1'b1, 32'h0,         1'b1},
    '{ActWrite, AddrSie,     32'hAAAA_AAAA, PrivSuper,   1'b1, 32'h0,         1'b1},
    '{ActRead,  AddrMie,     32'h0000_0000, PrivMachine, 1'b1, 32'hAAAA_AAAA, 1'b1},
    '{ActWrite, AddrMip,     32'hFFFF_FFFF, PrivMachine, 1'b1, 32'h0,         1'b1},
    '{ActRead,  AddrSip,     32'h0000_0000, PrivSuper,   1'b1, MipWMask,      1'b1},
    '{ActClear, AddrSip,     32'h0000_0200, PrivSuper,   1'b1, MipWMask,      1'b1},
    // A denied set still changes sstatus.
    '{ActSet,   AddrSstatus, 32'hFFFF_FFFF, PrivUser,    1'b0, 32'h0,         1'b0},
    '{ActRead,  AddrMstatus, 32'h0000_0000, PrivMachine, 1'b0, 32'h0,         1'b0},
    // Plain store: a denied write lands anyway, and the reserved mode 2 may read it back.
    '{ActWrite, 12'hABC,     32'hFFFF_FFFF, PrivUser,    1'b1, 32'h0,         1'b0},
    '{ActRead,  12'hABC,     32'h0000_0000, PrivRsvd,    1'b1, 32'hFFFF_FFFF, 1'b1},
    // The top address is read-only, so a set there is denied and has no effect.
    '{ActSet,   12'hFFF,     32'hFFFF_FFFF, PrivMachine, 1'b1, 32'h0,         1'b0},
    '{ActRead,  12'hFFF,     32'h0000_0000, PrivMachine, 1'b1, 32'h0,         1'b1},
    '{ActClear, AddrMip,     32'hFFFF_FFFF, PrivUser,    1'b0, 32'h0,         1'b0},
    '{ActWrite, AddrMisa,    32'h0000_0000, PrivMachine, 1'b1, MisaValue,     1'b1},
    '{ActRead,  12'h000,     32'hFFFF_FFFF, PrivUser,    1'b1, 32'h0,         1'b1},
    '{ActWrite, 12'h7FF,     32'h1234_5678, PrivMachine, 1'b0, 32'h0,         1'b0}
  };

  // Special addresses that the random part favors.
  localparam logic [11:0] MappedAddrs [10] = '{
    AddrSstatus, AddrSie, AddrSip, AddrMstatus, AddrMisa,
    AddrMideleg, AddrMie, AddrMip, AddrCycle, AddrCycleh
  };
  // A few store words that get hit again and again, so reads find earlier writes. Two of
  // them sit in the read-only range.
  localparam logic [11:0] StoreAddrs [8] = '{
    12'h000, 12'h0FF, 12'h340, 12'h5A5, 12'h7FF, 12'hABC, 12'hC01, 12'hFFF
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Everything offered on the input channel comes from this one variable, so the payload
  // and the typed expectation always change together.
  csr_row_t    offered   = '0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_read_data;
  logic        out_access_allowed;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  riscv_csr_file dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .in_action_i         (offered.action),
    .in_address_i        (offered.address),
    .in_value_i          (offered.value),
    .in_privilege_i      (offered.privilege),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .out_read_data_o     (out_read_data),
    .out_access_allowed_o(out_access_allowed)
  );

  // ---------------------------------------------------------------------------------------
  // Model of the CSR file. It tracks the dedicated registers, the fake cycle counter and a
  // copy of the backing store, and is advanced once per accepted transaction.
  // ---------------------------------------------------------------------------------------
  logic [31:0] mstatus_q;
  logic [31:0] mie_q;
  logic [31:0] mip_q;
  logic [31:0] mideleg_q;
  logic [31:0] cycle_q;
  logic [31:0] store_q [StoreDepth];

  // Register contents without side effects.
  function automatic logic [31:0] csr_peek(logic [11:0] addr);
    case (addr)
      AddrCycle:   return cycle_q;
      AddrCycleh:  return 32'h0;
      AddrSstatus: return mstatus_q & SstatusVMask;
      AddrSie:     return mie_q & mideleg_q;
      AddrSip:     return mip_q & mideleg_q;
      AddrMstatus: return mstatus_q;
      AddrMisa:    return MisaValue;
      AddrMideleg: return mideleg_q;
      AddrMie:     return mie_q;
      AddrMip:     return mip_q;
      default:     return store_q[addr];
    endcase
  endfunction

  // Applies the write rules of each register; read-only addresses drop the write.
  function automatic void csr_commit(logic [11:0] addr, logic [31:0] data);
    logic [31:0] mask;
    if (addr[11:10] == ReadOnlyTop) return;
    case (addr)
      AddrMstatus: begin
        data = data & MstatusWMask;
        if (data[MppLsb +: 2] == MppReserved) data[MppLsb +: 2] = 2'b00;
        mstatus_q = data;
      end
      AddrSstatus: mstatus_q = (mstatus_q & ~SstatusVMask) | (data & SstatusVMask);
      AddrSie: begin
        mask = mideleg_q;
        mie_q = (mie_q & ~mask) | (data & mask);
      end
      AddrSip: begin
        mask = mideleg_q & MipWMask;
        mip_q = (mip_q & ~mask) | (data & mask);
      end
      AddrMip:     mip_q = (mip_q & ~MipWMask) | (data & MipWMask);
      AddrMideleg: mideleg_q = data;
      AddrMie:     mie_q = data;
      AddrMisa:    ;
      default:     store_q[addr] = data;
    endcase
  endfunction

  // One full access: the permission flag is only reported, the access always happens.
  // A write returns the old value without read side effects; read, set and clear do bump
  // the cycle counter before returning it.
  function automatic csr_result_t csr_access(csrf_action_e act, logic [11:0] addr,
                                             logic [31:0] data, logic [1:0] priv);
    csr_result_t res;
    res.allowed = (priv >= addr[9:8]) && !(act != ActRead && addr[11:10] == ReadOnlyTop);
    if (act == ActWrite) begin
      res.read_data = csr_peek(addr);
      csr_commit(addr, data);
    end else begin
      if (addr == AddrCycle) cycle_q = cycle_q + CycleStep;
      res.read_data = csr_peek(addr);
      if (act == ActSet) csr_commit(addr, res.read_data | data);
      else if (act == ActClear) csr_commit(addr, res.read_data & ~data);
    end
    return res;
  endfunction

  initial begin
    mstatus_q = MstatusReset;
    mie_q     = '0;
    mip_q     = '0;
    mideleg_q = '0;
    cycle_q   = '0;
    foreach (store_q[i]) store_q[i] = '0;
  end

  // ---------------------------------------------------------------------------------------
  // Monitor and scoreboard. Both channels are sampled at the rising edge; inputs only move
  // at the falling edge, so the values seen here are the ones the block takes.
  // ---------------------------------------------------------------------------------------
  csr_result_t csr_results_due [$];
  csr_result_t due;
  csr_result_t computed;
  int unsigned error_count  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned act_count [4] = '{0, 0, 0, 0};
  int unsigned denied_count = 0;
  int unsigned checked_count = 0;
  logic        moved;

  always @(posedge clk) begin
    if (rst_n) begin
      moved = 1'b0;
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        moved = 1'b1;
        if (csr_results_due.size() == 0) begin
          $error("result with no transaction outstanding: read_data %h, access_allowed %b",
                 out_read_data, out_access_allowed);
          error_count++;
        end else begin
          due = csr_results_due.pop_front();
          checked_count++;
          if (out_read_data !== due.read_data) begin
            $error("read_data mismatch: expected %h, got %h", due.read_data, out_read_data);
            error_count++;
          end
          if (out_access_allowed !== due.allowed) begin
            $error("access_allowed mismatch: expected %b, got %b",
                   due.allowed, out_access_allowed);
            error_count++;
          end
        end
      end
      if (in_valid && in_stall === 1'b0) begin
        moved = 1'b1;
        // The model always runs so its state stays in step, even when the row types in
        // its own expectation.
        computed = csr_access(offered.action, offered.address, offered.value,
                              offered.privilege);
        if (offered.typed) csr_results_due.push_back('{offered.read_data, offered.allowed});
        else csr_results_due.push_back(computed);
        act_count[offered.action]++;
        if (!computed.allowed) denied_count++;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Idle pattern shared by both sides: mostly back to back, some short gaps, a few long.
  // ---------------------------------------------------------------------------------------
  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // calm switches idling off on both sides; hold_req asks the receiver for one long
  // hold-off while the sender keeps pushing.
  bit          calm     = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned stall_left = 0;

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req   = 1'b0;
      stall_left = HoldOffCycles;
    end else if (stall_left == 0 && !calm) begin
      stall_left = idle_length();
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------------------

  // Offers one transaction at a falling edge and returns at the falling edge after it was
  // taken, possibly after a random gap with valid low.
  task automatic offer_access(input csr_row_t row, input bit no_gap);
    int unsigned gap;
    offered  <= row;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
    gap = (no_gap || calm) ? 0 : idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Random access weighted toward the mapped registers and a small set of store words,
  // with the remainder spread over the whole address space.
  function automatic csr_row_t random_access();
    csr_row_t    row;
    int unsigned roll;
    row = '0;
    row.action    = csrf_action_e'($urandom_range(0, 3));
    row.privilege = 2'($urandom_range(0, 3));
    roll = $urandom_range(0, 99);
    if (roll < 40) row.address = MappedAddrs[$urandom_range(0, 9)];
    else if (roll < 65) row.address = StoreAddrs[$urandom_range(0, 7)];
    else row.address = 12'($urandom_range(0, StoreDepth - 1));
    roll = $urandom_range(0, 99);
    if (roll < 12) row.value = 32'h0;
    else if (roll < 24) row.value = 32'hFFFF_FFFF;
    else begin
      row.value = $urandom;
      // Walk the MPP field through all four codes, the reserved one included.
      if (roll < 45) row.value[MppLsb +: 2] = 2'($urandom_range(0, 3));
    end
    return row;
  endfunction

  int unsigned burst_end = 0;

  initial begin : stimulus
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DirectedCount; i++) offer_access(DirectedRows[i], 1'b0);

    for (int i = 0; i < RandomCount; i++) begin
      calm = (i % 250) < 50;
      // Long receiver hold-off with the sender never pausing: the output register and
      // whatever sits ahead of it fill up and the block has to stall its input.
      if (i == 300) begin
        hold_req  = 1'b1;
        burst_end = i + 80;
      end
      // Once, let everything drain before carrying on.
      if (i == 700) begin
        in_valid <= 1'b0;
        while (csr_results_due.size() != 0) @(negedge clk);
        @(negedge clk);
      end
      offer_access(random_access(), i < burst_end);
    end

    in_valid <= 1'b0;
    calm = 1'b1;
    while (csr_results_due.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);

    $display("Covered %0d transactions: %0d reads, %0d writes, %0d sets, %0d clears.",
             checked_count, act_count[ActRead], act_count[ActWrite], act_count[ActSet],
             act_count[ActClear]);
    $display("%0d of them were denied; the run included a %0d-cycle output hold-off and a drain.",
             denied_count, HoldOffCycles);
    if (error_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // Hang detection: too many cycles in a row without a transaction on either channel.
  initial begin : watchdog
    wait (quiet_cycles >= HangLimit);
    $display("Hang: no transaction for %0d cycles.", HangLimit);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
